/* design/dlts_pkg.sv */
`default_nettype none
package dlts_pkg;
	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_DEL = 2'd1;
	localparam logic [1:0] MODE_TICK = 2'd2;
	localparam logic [1:0] MODE_DISP = 2'd3;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  task_tag;
		logic [15:0] start_delay;
		logic [15:0] repeat_period;
		logic [31:0] target_id;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] new_id;
		logic [7:0]  run_tag;
		logic [15:0] run_period;
	} rsp_t;
endpackage
`default_nettype wire

/* design/dlts_front.sv */
`default_nettype none
// two-entry request queue between the port and the engine
module dlts_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	output logic              full,
	input  wire dlts_pkg::req_t req,
	output logic              vld,
	input  wire logic         take,
	output dlts_pkg::req_t    head
);
	import dlts_pkg::*;
	req_t mem_q [2];
	logic rp_q, wp_q;
	logic [1:0] cnt_q;
	logic do_push, do_pop;

	assign full = cnt_q == 2'd2;
	assign vld = cnt_q != 2'd0;
	assign head = mem_q[rp_q];
	assign do_push = push && !full;
	assign do_pop = take && vld;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q <= 1'b0;
			wp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wp_q <= ~wp_q;
			if (do_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count overflow");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> cnt_q == $past(cnt_q) - 2'd1)
		else $error("pop miscount");
	a_push: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("push miscount");
endmodule
`default_nettype wire

/* design/dlts_engine.sv */
`default_nettype none
// sequencer over the delta-list table; one entry is scanned per cycle
module dlts_engine #(
	parameter int N = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          vld,
	output logic               take,
	input  wire dlts_pkg::req_t req,
	output logic               empty,
	input  wire logic          pop,
	output dlts_pkg::rsp_t     rsp
);
	import dlts_pkg::*;
	localparam int IW = $clog2(N);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_INS = 3'd2;
	localparam logic [2:0] ST_DEL = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0] st_q;
	logic [N-1:0] val_q, rdy_q;
	logic [7:0]  tag_q [N];
	logic [15:0] dl_q [N];
	logic [15:0] per_q [N];
	logic [31:0] id_q [N];
	logic [31:0] idc_q;

	req_t cmd_q;
	logic [IW-1:0] i_q;
	logic [16:0] sum_q;
	logic [IW-1:0] pos_q;
	logic split_q;
	logic [16:0] newd_q;
	logic [15:0] splitd_q;
	logic [7:0]  itag_q;
	logic [15:0] iper_q;
	logic [15:0] idly_q;
	logic disp_q;
	rsp_t res_q;
	rsp_t out_q;
	logic full_q;

	logic [16:0] nsum;
	logic [31:0] nid;
	logic load_out;
	logic disp_go;
	rsp_t disp_rsp;

	assign nsum = sum_q + {1'b0, dl_q[i_q]};
	assign nid = (idc_q == 32'hFFFF_FFFF) ? 32'd1 : idc_q + 32'd1;
	assign take = st_q == ST_IDLE && vld;
	assign empty = !full_q;
	assign rsp = out_q;
	// finished transaction moves to the output register once it is free
	assign load_out = st_q == ST_DONE && (!full_q || pop);
	assign disp_go = req.mode == MODE_DISP && val_q[0] && rdy_q[0];

	always_comb begin
		disp_rsp = '0;
		disp_rsp.ok = 1'b1;
		disp_rsp.run_tag = tag_q[0];
		disp_rsp.run_period = per_q[0];
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_SCAN && cmd_q.mode == MODE_ADD && val_q[i_q] && nsum > {1'b0, idly_q}) begin
			splitd_q <= 16'(nsum - {1'b0, idly_q});
			newd_q <= {1'b0, idly_q} - sum_q;
		end else if (st_q == ST_SCAN) begin
			newd_q <= {1'b0, idly_q} - nsum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			val_q <= '0;
			rdy_q <= '0;
			idc_q <= '0;
			full_q <= 1'b0;
			res_q <= '0;
			out_q <= '0;
			for (int k = 0; k < N; k++) begin
				tag_q[k] <= '0; dl_q[k] <= '0; per_q[k] <= '0; id_q[k] <= '0;
			end
			cmd_q <= '0; i_q <= '0; sum_q <= '0; pos_q <= '0; split_q <= 1'b0;
			itag_q <= '0; iper_q <= '0; idly_q <= '0; disp_q <= 1'b0;
		end else begin
			if (load_out) full_q <= 1'b1;
			else if (pop && full_q) full_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (take) begin
						cmd_q <= req;
						res_q <= disp_go ? disp_rsp : '0;
						i_q <= '0;
						sum_q <= '0;
						disp_q <= disp_go && per_q[0] != 16'd0;
						itag_q <= disp_go ? tag_q[0] : req.task_tag;
						idly_q <= disp_go ? per_q[0] : req.start_delay;
						iper_q <= disp_go ? per_q[0] : req.repeat_period;
						unique case (req.mode)
							MODE_ADD: begin
								if (val_q[N-1]) st_q <= ST_DONE;
								else if (!val_q[0]) begin
									pos_q <= '0; split_q <= 1'b0; st_q <= ST_INS;
								end else st_q <= ST_SCAN;
							end
							MODE_DEL: st_q <= (req.target_id == 32'd0) ? ST_DONE : ST_SCAN;
							MODE_TICK: begin
								if (val_q[0] && !rdy_q[0]) begin
									if (dl_q[0] > 16'd1) dl_q[0] <= dl_q[0] - 16'd1;
									else begin
										dl_q[0] <= 16'd0; rdy_q[0] <= 1'b1;
									end
								end
								st_q <= ST_DONE;
							end
							default: begin
								if (disp_go) begin
									pos_q <= '0;
									st_q <= ST_DEL;
								end else st_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (cmd_q.mode == MODE_DEL) begin
						if (val_q[i_q] && id_q[i_q] == cmd_q.target_id) begin
							res_q.ok <= 1'b1; pos_q <= i_q; st_q <= ST_DEL;
						end else if (i_q == IW'(N - 1)) st_q <= ST_DONE;
						else i_q <= i_q + 1'b1;
					end else begin
						if (val_q[i_q] && nsum > {1'b0, idly_q}) begin
							pos_q <= i_q; split_q <= 1'b1; st_q <= ST_INS;
						end else if (i_q == IW'(N - 1) || !val_q[i_q + 1'b1]) begin
							pos_q <= i_q + 1'b1; split_q <= 1'b0; st_q <= ST_INS;
						end else begin
							sum_q <= nsum; i_q <= i_q + 1'b1;
						end
					end
				end
				ST_DEL: begin
					// shift up and pass the removed delay on, saturating
					for (int k = 0; k < N; k++) begin
						if (IW'(k) >= pos_q) begin
							if (k == N - 1) begin
								val_q[k] <= 1'b0; rdy_q[k] <= 1'b0; tag_q[k] <= '0;
								dl_q[k] <= '0; per_q[k] <= '0; id_q[k] <= '0;
							end else begin
								val_q[k] <= val_q[k+1]; rdy_q[k] <= rdy_q[k+1];
								tag_q[k] <= tag_q[k+1]; per_q[k] <= per_q[k+1];
								id_q[k] <= id_q[k+1];
								if (IW'(k) == pos_q && val_q[k+1])
									dl_q[k] <= ({1'b0, dl_q[k+1]} + {1'b0, dl_q[k]} > 17'hFFFF)
										? 16'hFFFF : dl_q[k+1] + dl_q[k];
								else dl_q[k] <= dl_q[k+1];
							end
						end
					end
					if (disp_q) begin
						i_q <= '0; sum_q <= '0;
						// head was the only entry: table is empty after the shift
						if (!val_q[1]) begin
							pos_q <= '0; split_q <= 1'b0; st_q <= ST_INS;
						end else st_q <= ST_SCAN;
						cmd_q.mode <= MODE_ADD;
					end else st_q <= ST_DONE;
				end
				ST_INS: begin
					for (int k = 1; k < N; k++) begin
						if (IW'(k) > pos_q) begin
							val_q[k] <= val_q[k-1]; rdy_q[k] <= rdy_q[k-1];
							tag_q[k] <= tag_q[k-1]; per_q[k] <= per_q[k-1];
							id_q[k] <= id_q[k-1];
							dl_q[k] <= (IW'(k) == pos_q + 1'b1 && split_q) ? splitd_q : dl_q[k-1];
						end
					end
					idc_q <= nid;
					val_q[pos_q] <= 1'b1;
					tag_q[pos_q] <= itag_q;
					per_q[pos_q] <= iper_q;
					id_q[pos_q] <= nid;
					// empty table: no scan ran, the delay goes in as is
					if (sum_q == 17'd0 && !split_q && pos_q == '0) begin
						dl_q[pos_q] <= idly_q; rdy_q[pos_q] <= idly_q == 16'd0;
					end else begin
						dl_q[pos_q] <= 16'(newd_q); rdy_q[pos_q] <= newd_q == 17'd0;
					end
					if (!disp_q) begin
						res_q.ok <= 1'b1; res_q.new_id <= nid;
					end
					st_q <= ST_DONE;
				end
				default: begin
					if (load_out) begin
						out_q <= res_q; st_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_INS |-> !val_q[N-1])
		else $error("insert into full table");
	a_pack: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_IDLE |-> ((val_q & (val_q + 1'b1)) == '0))
		else $error("table not packed");
	a_id: assert property (@(posedge clk) disable iff (!arst_n)
		full_q && out_q.new_id != 32'd0 |-> out_q.ok)
		else $error("id without ok");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		full_q && !pop |=> $stable(out_q))
		else $error("result changed while waiting");
endmodule
`default_nettype wire

/* design/delta_list_task_scheduler.sv */
`default_nettype none
// Delta-list timer queue.
// Requests enter a queue port: push/full, accepted when push && !full.
// A request adds a task, deletes one by id, ticks the head or dispatches it.
// Results leave a queue port: empty/pop; the result is on rsp while empty
// is low and is taken when pop && !empty. Exactly one result per request.
// A two-deep request queue lets the caller push while the engine works.
// Tick and requests rejected on entry go straight to the result; an add into
// an empty table inserts at once, else it scans one entry per cycle and then
// inserts; delete scans and then removes; dispatch removes a ready head and
// re-adds it when it has a period. Requests are handled one at a time by the
// table sequencer, which sets the rate: a new request is taken only after the previous one finishes.
// While a result is not popped the engine finishes the next request and
// holds it, then the request queue fills and full rises. Reset empties the
// table, both queues and the id counter; ids start at 1, wrap and never
// take the value 0.
module delta_list_task_scheduler #(
	parameter int MAX_TASKS = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire dlts_pkg::req_t req,
	output logic               empty,
	input  wire logic          pop,
	output dlts_pkg::rsp_t     rsp
);
	import dlts_pkg::*;
	req_t hd;
	logic vld, take;

	dlts_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req(req),
		.vld(vld), .take(take), .head(hd)
	);

	dlts_engine #(.N(MAX_TASKS)) u_engine (
		.clk(clk), .arst_n(arst_n), .vld(vld), .take(take), .req(hd),
		.empty(empty), .pop(pop), .rsp(rsp)
	);
endmodule
`default_nettype wire

/* test/delta_list_task_scheduler_tb.sv */
`default_nettype none
module delta_list_task_scheduler_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dlts_pkg::*;

	localparam int NTASK = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	req_t req = '0;
	logic empty;
	logic pop = 1'b0;
	rsp_t rsp;

	delta_list_task_scheduler #(.MAX_TASKS(NTASK)) dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req(req),
		.empty(empty), .pop(pop), .rsp(rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// scheduler shadow state
	logic        sh_valid [NTASK];
	logic [7:0]  sh_tag [NTASK];
	logic [15:0] sh_delta [NTASK];
	logic [15:0] sh_period [NTASK];
	logic        sh_ready [NTASK];
	logic [31:0] sh_id [NTASK];
	logic [31:0] sh_id_ctr;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int errors = 0;
	int n_sent = 0;
	int n_seen = 0;
	int n_disp = 0;
	int n_reject = 0;
	bit drain_hold = 0;
	bit no_idle = 0;
	bit stim_done = 0;
	int tx_gap = 0;
	int rx_gap = 0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch %0s: got %0h expected %0h (result %0d)", what, got, want, n_seen);
		errors++;
	endtask

	function automatic int used_slots();
		int n;
		n = 0;
		while (n < NTASK && sh_valid[n]) n++;
		return n;
	endfunction

	function automatic void move_slot(int d, int s);
		sh_valid[d] = sh_valid[s];
		sh_tag[d] = sh_tag[s];
		sh_delta[d] = sh_delta[s];
		sh_period[d] = sh_period[s];
		sh_ready[d] = sh_ready[s];
		sh_id[d] = sh_id[s];
	endfunction

	function automatic void drop_slot(int pos);
		logic [16:0] s;
		if (pos + 1 < NTASK && sh_valid[pos + 1]) begin
			s = {1'b0, sh_delta[pos + 1]} + {1'b0, sh_delta[pos]};
			sh_delta[pos + 1] = s[16] ? 16'hffff : s[15:0];
		end
		for (int j = pos; j + 1 < NTASK; j++) move_slot(j, j + 1);
		sh_valid[NTASK - 1] = 0;
		sh_tag[NTASK - 1] = '0;
		sh_delta[NTASK - 1] = '0;
		sh_period[NTASK - 1] = '0;
		sh_ready[NTASK - 1] = 0;
		sh_id[NTASK - 1] = '0;
	endfunction

	function automatic logic [31:0] place_task(logic [7:0] tg, logic [15:0] dly,
		logic [15:0] per);
		int cnt, pos;
		logic [31:0] sum, newd;
		cnt = used_slots();
		pos = cnt;
		sum = '0;
		if (cnt >= NTASK) return '0;
		for (int i = 0; i < cnt; i++) begin
			sum += 32'(sh_delta[i]);
			if (sum > 32'(dly)) begin
				pos = i;
				break;
			end
		end
		if (pos < cnt) begin
			newd = 32'(dly) - (sum - 32'(sh_delta[pos]));
			sh_delta[pos] = 16'(sum - 32'(dly));
			for (int i = cnt; i > pos; i--) move_slot(i, i - 1);
		end else begin
			newd = 32'(dly) - sum;
		end
		sh_id_ctr++;
		if (sh_id_ctr == 0) sh_id_ctr = 1;
		sh_valid[pos] = 1;
		sh_tag[pos] = tg;
		sh_delta[pos] = newd[15:0];
		sh_period[pos] = per;
		sh_ready[pos] = (newd == 0);
		sh_id[pos] = sh_id_ctr;
		return sh_id_ctr;
	endfunction

	function automatic rsp_t schedule_step(req_t r);
		rsp_t o;
		logic [31:0] id;
		logic [7:0] t;
		logic [15:0] p;
		o = '0;
		case (r.mode)
			MODE_ADD: begin
				id = place_task(r.task_tag, r.start_delay, r.repeat_period);
				if (id != 0) begin
					o.ok = 1;
					o.new_id = id;
				end else begin
					n_reject++;
				end
			end
			MODE_DEL: begin
				if (r.target_id != 0)
					for (int i = 0; i < NTASK; i++)
						if (sh_valid[i] && sh_id[i] == r.target_id) begin
							drop_slot(i);
							o.ok = 1;
							break;
						end
			end
			MODE_TICK: begin
				if (sh_valid[0] && !sh_ready[0]) begin
					if (sh_delta[0] > 0) sh_delta[0]--;
					if (sh_delta[0] == 0) sh_ready[0] = 1;
				end
			end
			default: begin
				if (sh_valid[0] && sh_ready[0]) begin
					t = sh_tag[0];
					p = sh_period[0];
					o.ok = 1;
					o.run_tag = t;
					o.run_period = p;
					n_disp++;
					drop_slot(0);
					if (p != 0) void'(place_task(t, p, p));
				end
			end
		endcase
		return o;
	endfunction

	function automatic req_t make_req(logic [1:0] m, logic [7:0] tg, logic [15:0] dly,
		logic [15:0] per, logic [31:0] tid);
		req_t r;
		r.mode = m;
		r.task_tag = tg;
		r.start_delay = dly;
		r.repeat_period = per;
		r.target_id = tid;
		return r;
	endfunction

	function automatic logic [31:0] pick_target();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return $urandom();
			2: return 32'hffffffff;
			default: return $urandom_range(1, 40 + n_sent / 2);
		endcase
	endfunction

	function automatic logic [15:0] pick_delay();
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'hffff;
			2: return 16'($urandom());
			default: return 16'($urandom_range(0, 12));
		endcase
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				expected_rsps.push_back(schedule_step(req));
				n_sent++;
			end
			if (push && full) begin
				// keep request up until taken
			end else if (drain_hold && expected_rsps.size() != 0) begin
				push <= 1'b0;
			end else if (tx_gap > 0) begin
				tx_gap <= tx_gap - 1;
				push <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 15) == 0) begin
				tx_gap <= $urandom_range(0, 11);
				push <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				req <= pending_reqs.pop_front();
				push <= 1'b1;
			end else begin
				push <= 1'b0;
				if (pending_reqs.size() == 0 && stim_done) begin
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_rsps.size() == 0) begin
					$display("unexpected result %0h", rsp);
					errors++;
				end else begin
					rsp_t e;
					e = expected_rsps.pop_front();
					if (rsp.ok !== e.ok) report_mismatch("ok", 32'(rsp.ok), 32'(e.ok));
					if (rsp.new_id !== e.new_id) report_mismatch("new_id", rsp.new_id, e.new_id);
					if (rsp.run_tag !== e.run_tag)
						report_mismatch("run_tag", 32'(rsp.run_tag), 32'(e.run_tag));
					if (rsp.run_period !== e.run_period)
						report_mismatch("run_period", 32'(rsp.run_period), 32'(e.run_period));
				end
				n_seen++;
			end
			if (rx_gap > 0) begin
				rx_gap <= rx_gap - 1;
				pop <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 15) == 0) begin
				rx_gap <= $urandom_range(0, 11);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		int k;
		for (int i = 0; i < NTASK; i++) begin
			sh_valid[i] = 0; sh_tag[i] = '0; sh_delta[i] = '0;
			sh_period[i] = '0; sh_ready[i] = 0; sh_id[i] = '0;
		end
		sh_id_ctr = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty-table cases, extremes, full table, tail delete
		pending_reqs.push_back(make_req(MODE_DISP, 8'h00, 16'h0, 16'h0, 32'h0));
		pending_reqs.push_back(make_req(MODE_TICK, 8'h00, 16'h0, 16'h0, 32'h0));
		pending_reqs.push_back(make_req(MODE_DEL, 8'h00, 16'h0, 16'h0, 32'h0));
		pending_reqs.push_back(make_req(MODE_ADD, 8'hff, 16'h0, 16'hffff, 32'hffffffff));
		pending_reqs.push_back(make_req(MODE_DISP, 8'h00, 16'h0, 16'h0, 32'h0));
		pending_reqs.push_back(make_req(MODE_ADD, 8'h00, 16'hffff, 16'h0, 32'h0));
		pending_reqs.push_back(make_req(MODE_ADD, 8'h5a, 16'd3, 16'd2, 32'h0));
		pending_reqs.push_back(make_req(MODE_DEL, 8'h00, 16'h0, 16'h0, 32'd3));
		for (int i = 0; i < NTASK + 1; i++)
			pending_reqs.push_back(make_req(MODE_ADD, 8'(i), 16'(i * 3 % 7), 16'(i % 3),
				32'h0));
		pending_reqs.push_back(make_req(MODE_DEL, 8'h00, 16'h0, 16'h0, 32'hffffffff));

		// random, weighted toward valid ids and ticks so tasks come due
		for (int i = 0; i < 1250; i++) begin
			k = $urandom_range(0, 99);
			if (k < 30)
				pending_reqs.push_back(make_req(MODE_ADD, 8'($urandom()), pick_delay(),
					($urandom_range(0, 2) == 0) ? 16'd0 : pick_delay(), $urandom()));
			else if (k < 45)
				pending_reqs.push_back(make_req(MODE_DEL, 8'($urandom()), 16'($urandom()),
					16'($urandom()), pick_target()));
			else if (k < 75)
				pending_reqs.push_back(make_req(MODE_TICK, 8'($urandom()), 16'($urandom()),
					16'($urandom()), $urandom()));
			else
				pending_reqs.push_back(make_req(MODE_DISP, 8'($urandom()), 16'($urandom()),
					16'($urandom()), $urandom()));
			if (i == 600) begin
				// let the pending request list drain to at most one entry before the second half
				wait (pending_reqs.size() <= 1);
			end
		end
		drain_hold = 1;
		wait (pending_reqs.size() < 1000 && expected_rsps.size() == 0);
		@(posedge clk);
		wait (expected_rsps.size() == 0 && !push);
		drain_hold = 0;
		wait (pending_reqs.size() < 150);
		no_idle = 1;
		wait (pending_reqs.size() == 0 && !push);
		wait (expected_rsps.size() == 0);
		repeat (40) @(posedge clk);
		stim_done = 1;
		$display("%0d requests, %0d results, %0d dispatches, %0d full-table rejects",
			n_sent, n_seen, n_disp, n_reject);
		if (errors == 0 && expected_rsps.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end
endmodule
`default_nettype wire
